// File: rtl/rgblap_pkg.sv
// Shared constants, types and the per-channel clamp for the RGB Laplacian filter.
// No dependencies; used by rgb_laplacian_3x3_filter_top.
`default_nettype none

package rgblap_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int ROW_W      = 16;
  localparam int COL_OUT_W  = 10;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd768;

  // register index is paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [RGB_W-1:0] pixel_t;

  // where the current centre sits in the frame
  typedef struct packed {
    logic has_any;
    logic top;
    logic left;
    logic last;
    logic right;
  } pos_flags_t;

  // (u + l + r + d) - 4c, clamped to 0..255
  function automatic logic [PIX_W-1:0] lap_clamp(input logic [PIX_W-1:0] u,
                                                 input logic [PIX_W-1:0] l,
                                                 input logic [PIX_W-1:0] c,
                                                 input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] d);
    logic [PIX_W+1:0] nsum;
    logic [PIX_W+2:0] diff;
    nsum = 10'(u) + 10'(l) + 10'(r) + 10'(d);
    diff = {1'b0, nsum} - {1'b0, c, 2'b00};
    if (diff[PIX_W+2]) begin
      return '0;
    end else if (diff[PIX_W+1:PIX_W] != 2'b00) begin
      return '1;
    end else begin
      return diff[PIX_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/rgb_laplacian_3x3_filter_top.sv
// RGB 3x3 four-neighbour Laplacian with reflect-101 borders: two line stores,
// a 3x3 window, result sequencing and an APB register port. Uses rgblap_pkg.
//
// Usage
//   Pixels enter in raster order on in_valid/in_stall (red, green, blue).
//   Filtered words leave on out_valid/out_stall, tagged with out_row and
//   out_column; run_last marks the final word caused by one input pixel.
//   image_width (0x0) and image_height (0x4) are set over APB while idle.
// Timing
//   A pixel is registered at accept while its column is read from both line
//   stores; the window loads from these registers when stage 1 advances, and
//   the first result then loads into the output register, which drives out_valid.
//   One pixel per cycle in steady state while out_stall is low. A pixel that
//   causes n words (2 on the last row or the right column, 4 at the bottom-right
//   corner) holds the sequencer until all n have gone into the single output register.
//   The first row and column 0 produce no words.
// Reset
//   Counters go to the frame start, registers to 1024 x 768; the line
//   stores are not cleared.
// Stall
//   A stalled output word holds; the pipe fills behind it and in_stall rises.
`default_nettype none

module rgb_laplacian_3x3_filter_top #(
  parameter int MAX_WIDTH = rgblap_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // APB
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rgblap_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [rgblap_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [rgblap_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                     pready,
  // pixel input
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [rgblap_pkg::PIX_W-1:0]        pixel_red,
  input  wire logic [rgblap_pkg::PIX_W-1:0]        pixel_green,
  input  wire logic [rgblap_pkg::PIX_W-1:0]        pixel_blue,
  // result output
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [rgblap_pkg::ROW_W-1:0]        out_row,
  output logic      [rgblap_pkg::COL_OUT_W-1:0]    out_column,
  output logic      [rgblap_pkg::PIX_W-1:0]        filtered_red,
  output logic      [rgblap_pkg::PIX_W-1:0]        filtered_green,
  output logic      [rgblap_pkg::PIX_W-1:0]        filtered_blue,
  output logic                                     run_last
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int RW = rgblap_pkg::ROW_W;
  localparam int PW = rgblap_pkg::PIX_W;

  typedef enum logic [1:0] {K_UP_L, K_LO_L, K_UP_R, K_LO_R} kind_t;

  // ---------------- configuration ----------------
  logic [rgblap_pkg::IMG_W_W-1:0] image_width;
  logic [rgblap_pkg::IMG_H_W-1:0] image_height;
  logic                           cfg_wr;
  logic                           cfg_sel;
  logic [EW-1:0]                  eff_w;
  logic [RW-1:0]                  eff_h;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rgblap_pkg::WIDTH_RESET;
      image_height <= rgblap_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        rgblap_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[rgblap_pkg::IMG_W_W-1:0];
        rgblap_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[rgblap_pkg::IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      rgblap_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      rgblap_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:                      prdata = '0;
    endcase
  end

  // clamp to 2..MAX_WIDTH and 2..
  always_comb begin
    if (32'(image_width) < 32'd2) begin
      eff_w = EW'(2);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(image_width);
    end
    eff_h = (image_height < 16'd2) ? 16'd2 : image_height;
  end

  // ---------------- pipeline control ----------------
  logic s1_valid;
  logic s2_pend;
  logic s2_free;
  logic s1_adv;
  logic accept;
  logic o_load;
  logic next_done;

  assign o_load   = s2_pend & (~out_valid | ~out_stall);
  assign s2_free  = ~s2_pend | (o_load & next_done);
  assign s1_adv   = s1_valid & s2_free;
  assign in_stall = s1_valid & ~s2_free;
  assign accept   = in_valid & ~in_stall;

  // ---------------- position counters ----------------
  logic [CW-1:0] column_counter;
  logic [RW-1:0] row_counter;
  logic          col_over;
  logic [RW:0]   y_pre;
  logic [CW-1:0] x_now;
  logic [RW-1:0] y_now;
  logic [EW-1:0] x_inc;
  logic [RW:0]   y_inc;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  always_comb begin
    // counters left beyond the frame by a register change start a new row/frame
    col_over = EW'(column_counter) >= eff_w;
    y_pre    = col_over ? ({1'b0, row_counter} + 17'd1) : {1'b0, row_counter};
    x_now    = col_over ? '0 : column_counter;
    y_now    = (y_pre >= {1'b0, eff_h}) ? '0 : y_pre[RW-1:0];
    x_inc    = EW'(x_now) + EW'(1);
    y_inc    = {1'b0, y_now} + 17'd1;
    if (x_inc >= eff_w) begin
      col_next = '0;
      row_next = (y_inc >= {1'b0, eff_h}) ? '0 : y_inc[RW-1:0];
    end else begin
      col_next = CW'(x_inc);
      row_next = y_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
    end else if (accept) begin
      column_counter <= col_next;
      row_counter    <= row_next;
    end
  end

  // ---------------- stage 1: input register and line store read ----------------
  rgblap_pkg::pixel_t older_line    [MAX_WIDTH];
  rgblap_pkg::pixel_t previous_line [MAX_WIDTH];
  rgblap_pkg::pixel_t rd_older;
  rgblap_pkg::pixel_t rd_prev;
  rgblap_pkg::pixel_t s1_px;
  logic [CW-1:0]      s1_x;
  logic [RW-1:0]      s1_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept | (s1_valid & ~s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px <= {pixel_blue, pixel_green, pixel_red};
      s1_x  <= x_now;
      s1_y  <= y_now;
    end
  end

  // read at accept, write back when the word moves on; consecutive pixels
  // never share a column, so the two ports never meet on one entry
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_older <= older_line[x_now];
      rd_prev  <= previous_line[x_now];
    end
    if (s1_adv) begin
      older_line[s1_x]    <= rd_prev;
      previous_line[s1_x] <= s1_px;
    end
  end

  rgblap_pkg::pos_flags_t s1_flags;

  always_comb begin
    s1_flags.has_any = (s1_y != '0) && (s1_x != '0);
    s1_flags.top     = s1_y == RW'(1);
    s1_flags.left    = s1_x == CW'(1);
    s1_flags.last    = s1_y == (eff_h - 16'd1);
    s1_flags.right   = EW'(s1_x) == (eff_w - EW'(1));
  end

  // ---------------- stage 2: window and result sequencer ----------------
  rgblap_pkg::pixel_t     win [3][3];
  rgblap_pkg::pos_flags_t s2_flags;
  logic [CW-1:0]          s2_x;
  logic [RW-1:0]          s2_y;
  kind_t                  s2_kind;
  kind_t                  kind_nxt;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
      s2_pend <= 1'b0;
      s2_kind <= K_UP_L;
    end else if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= rd_older;
      win[1][2] <= rd_prev;
      win[2][2] <= s1_px;
      s2_pend   <= s1_flags.has_any;
      s2_kind   <= K_UP_L;
    end else if (o_load) begin
      s2_kind <= kind_nxt;
      // last word of this pixel gone and nothing behind it
      if (next_done) begin
        s2_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_flags <= s1_flags;
      s2_x     <= s1_x;
      s2_y     <= s1_y;
    end
  end

  always_comb begin
    kind_nxt  = s2_kind;
    next_done = 1'b1;
    case (s2_kind)
      K_UP_L: begin
        if (s2_flags.last) begin
          kind_nxt  = K_LO_L;
          next_done = 1'b0;
        end else if (s2_flags.right) begin
          kind_nxt  = K_UP_R;
          next_done = 1'b0;
        end
      end
      K_LO_L: begin
        if (s2_flags.right) begin
          kind_nxt  = K_UP_R;
          next_done = 1'b0;
        end
      end
      K_UP_R: begin
        if (s2_flags.last) begin
          kind_nxt  = K_LO_R;
          next_done = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // taps for the current result; the lower-row forms mirror the row above
  rgblap_pkg::pixel_t t_u, t_l, t_c, t_r, t_d;
  logic [RW-1:0]      res_row;
  logic [CW-1:0]      res_col;

  always_comb begin
    case (s2_kind)
      K_UP_L: begin
        t_c = win[1][1];
        t_u = s2_flags.top ? win[2][1] : win[0][1];
        t_d = win[2][1];
        t_l = s2_flags.left ? win[1][2] : win[1][0];
        t_r = win[1][2];
      end
      K_LO_L: begin
        t_c = win[2][1];
        t_u = win[1][1];
        t_d = win[1][1];
        t_l = s2_flags.left ? win[2][2] : win[2][0];
        t_r = win[2][2];
      end
      K_UP_R: begin
        t_c = win[1][2];
        t_u = s2_flags.top ? win[2][2] : win[0][2];
        t_d = win[2][2];
        t_l = win[1][1];
        t_r = win[1][1];
      end
      default: begin
        t_c = win[2][2];
        t_u = win[1][2];
        t_d = win[1][2];
        t_l = win[2][1];
        t_r = win[2][1];
      end
    endcase
    res_row = (s2_kind == K_UP_L || s2_kind == K_UP_R) ? (s2_y - 16'd1) : s2_y;
    res_col = (s2_kind == K_UP_L || s2_kind == K_LO_L) ? (s2_x - CW'(1)) : s2_x;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= o_load | (out_valid & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      out_row        <= res_row;
      out_column     <= rgblap_pkg::COL_OUT_W'(res_col);
      filtered_red   <= rgblap_pkg::lap_clamp(t_u[PW-1:0], t_l[PW-1:0], t_c[PW-1:0],
                                              t_r[PW-1:0], t_d[PW-1:0]);
      filtered_green <= rgblap_pkg::lap_clamp(t_u[2*PW-1:PW], t_l[2*PW-1:PW],
                                              t_c[2*PW-1:PW], t_r[2*PW-1:PW],
                                              t_d[2*PW-1:PW]);
      filtered_blue  <= rgblap_pkg::lap_clamp(t_u[3*PW-1:2*PW], t_l[3*PW-1:2*PW],
                                              t_c[3*PW-1:2*PW], t_r[3*PW-1:2*PW],
                                              t_d[3*PW-1:2*PW]);
      run_last       <= next_done;
    end
  end

`ifndef SYNTHESIS
  // write-back and a new read never hit the same column
  a_no_store_clash: assert property (@(posedge clk) disable iff (rst)
    s1_adv && accept |-> s1_x != x_now)
    else $error("line store read and write on one column");

  // a pixel waiting in stage 1 keeps its column until the sequencer frees
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_free |=> s1_valid && $stable(s1_x) && $stable(s1_y))
    else $error("stage 1 lost a pixel while blocked");

  // lower-row words only on the last row, right-column words only at the edge
  a_lower_only_last: assert property (@(posedge clk) disable iff (rst)
    o_load && (s2_kind == K_LO_L || s2_kind == K_LO_R) |-> s2_flags.last)
    else $error("last-row word outside the last row");

  a_right_only_edge: assert property (@(posedge clk) disable iff (rst)
    o_load && (s2_kind == K_UP_R || s2_kind == K_LO_R) |-> s2_flags.right)
    else $error("right-border word away from the right edge");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking bench for rgb_laplacian_3x3_filter_top: queued pixel driver, result monitor
// and a line-store/window predictor of the 4-neighbour Laplacian with reflect-101 borders.
// Depends on rgblap_pkg and the top-level RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W       = rgblap_pkg::DEF_MAX_WIDTH;
  localparam int FILL_W      = 40;
  localparam int IDLE_CYCLES = 16;

  typedef struct packed {
    logic [rgblap_pkg::ROW_W-1:0]     row;
    logic [rgblap_pkg::COL_OUT_W-1:0] column;
    logic [rgblap_pkg::PIX_W-1:0]     red;
    logic [rgblap_pkg::PIX_W-1:0]     green;
    logic [rgblap_pkg::PIX_W-1:0]     blue;
    logic                             last;
  } filtered_t;

  logic clk;
  logic rst = 1'b1;

  logic                              psel    = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite  = 1'b0;
  logic [rgblap_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [rgblap_pkg::APB_DATA_W-1:0] pwdata  = '0;
  wire  [rgblap_pkg::APB_DATA_W-1:0] prdata;
  wire                               pready;

  logic                         in_valid    = 1'b0;
  wire                          in_stall;
  logic [rgblap_pkg::PIX_W-1:0] pixel_red   = '0;
  logic [rgblap_pkg::PIX_W-1:0] pixel_green = '0;
  logic [rgblap_pkg::PIX_W-1:0] pixel_blue  = '0;

  wire                             out_valid;
  logic                            out_stall = 1'b0;
  wire [rgblap_pkg::ROW_W-1:0]     out_row;
  wire [rgblap_pkg::COL_OUT_W-1:0] out_column;
  wire [rgblap_pkg::PIX_W-1:0]     filtered_red;
  wire [rgblap_pkg::PIX_W-1:0]     filtered_green;
  wire [rgblap_pkg::PIX_W-1:0]     filtered_blue;
  wire                             run_last;

  rgb_laplacian_3x3_filter_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel_red      (pixel_red),
    .pixel_green    (pixel_green),
    .pixel_blue     (pixel_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_column     (out_column),
    .filtered_red   (filtered_red),
    .filtered_green (filtered_green),
    .filtered_blue  (filtered_blue),
    .run_last       (run_last)
  );

  // stimulus and expected words
  rgblap_pkg::pixel_t pixel_q[$];
  filtered_t          filtered_q[$];
  int                 errors = 0;

  // predictor state
  logic [rgblap_pkg::IMG_W_W-1:0] cfg_width  = rgblap_pkg::WIDTH_RESET;
  logic [rgblap_pkg::IMG_H_W-1:0] cfg_height = rgblap_pkg::HEIGHT_RESET;
  rgblap_pkg::pixel_t             older_mem[MAX_W];
  rgblap_pkg::pixel_t             prev_mem[MAX_W];
  rgblap_pkg::pixel_t             win[3][3];
  int                             row_cnt = 0;
  int                             col_cnt = 0;

  // handshake pacing
  rgblap_pkg::pixel_t drv_px     = '0;
  int                 gap_left   = 0;
  int                 stall_left = 0;
  int                 in_calm    = 0;
  int                 out_calm   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("%0t: watchdog expired", $time);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [rgblap_pkg::PIX_W-1:0] lap_clamp8(
      input logic [rgblap_pkg::PIX_W-1:0] u,
      input logic [rgblap_pkg::PIX_W-1:0] l,
      input logic [rgblap_pkg::PIX_W-1:0] c,
      input logic [rgblap_pkg::PIX_W-1:0] r,
      input logic [rgblap_pkg::PIX_W-1:0] d);
    int s;
    s = int'(u) + int'(l) + int'(r) + int'(d) - 4 * int'(c);
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return rgblap_pkg::PIX_W'(s);
  endfunction

  function automatic filtered_t window_word(input int orow, input int ocol,
                                            input int cr, input int cc,
                                            input int ur, input int dr,
                                            input int lc, input int rc);
    filtered_t                    f;
    rgblap_pkg::pixel_t           u, d, c, l, r;
    logic [rgblap_pkg::PIX_W-1:0] ch[3];
    u = win[ur][cc];
    d = win[dr][cc];
    c = win[cr][cc];
    l = win[cr][lc];
    r = win[cr][rc];
    for (int k = 0; k < 3; k++) begin
      ch[k] = lap_clamp8(u[8*k +: 8], l[8*k +: 8], c[8*k +: 8], r[8*k +: 8], d[8*k +: 8]);
    end
    f.row    = rgblap_pkg::ROW_W'(orow);
    f.column = rgblap_pkg::COL_OUT_W'(ocol);
    f.red    = ch[0];
    f.green  = ch[1];
    f.blue   = ch[2];
    f.last   = 1'b0;
    return f;
  endfunction

  task automatic predict_laplacian(input rgblap_pkg::pixel_t px);
    int        w, h, x, y, n, up, lc;
    logic      bottom;
    filtered_t words[4];
    w = int'(cfg_width);
    if (w < 2) w = 2;
    if (w > MAX_W) w = MAX_W;
    h = (cfg_height < 2) ? 2 : int'(cfg_height);
    // counters left beyond the frame by a size change
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    x = col_cnt;
    y = row_cnt;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = older_mem[x];
    win[1][2] = prev_mem[x];
    win[2][2] = px;
    older_mem[x] = prev_mem[x];
    prev_mem[x]  = px;
    n = 0;
    if (y >= 1 && x >= 1) begin
      // reflect-101: a missing neighbour is taken from the far side
      up     = (y == 1) ? 2 : 0;
      lc     = (x == 1) ? 2 : 0;
      bottom = (y == h - 1);
      words[n] = window_word(y - 1, x - 1, 1, 1, up, 2, lc, 2);
      n++;
      if (bottom) begin
        words[n] = window_word(y, x - 1, 2, 1, 1, 1, lc, 2);
        n++;
      end
      if (x == w - 1) begin
        words[n] = window_word(y - 1, x, 1, 2, up, 2, 1, 1);
        n++;
        if (bottom) begin
          words[n] = window_word(y, x, 2, 2, 1, 1, 1, 1);
          n++;
        end
      end
    end
    if (n > 0) words[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) filtered_q.push_back(words[i]);
    col_cnt = x + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = y + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  // mostly back to back, some short gaps, a few long ones, now and then a calm stretch
  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(40, 150);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) predict_laplacian(drv_px);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pixel_q.size() > 0) begin
          drv_px = pixel_q.pop_front();
          pixel_red   <= drv_px[7:0];
          pixel_green <= drv_px[15:8];
          pixel_blue  <= drv_px[23:16];
          in_valid    <= 1'b1;
          gap_left = pick_idle(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    filtered_t e;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected word, actual row %0d column %0d", $time, out_row,
                   out_column);
          errors++;
        end else begin
          e = filtered_q.pop_front();
          check_field("out_row", 32'(e.row), 32'(out_row));
          check_field("out_column", 32'(e.column), 32'(out_column));
          check_field("filtered_red", 32'(e.red), 32'(filtered_red));
          check_field("filtered_green", 32'(e.green), 32'(filtered_green));
          check_field("filtered_blue", 32'(e.blue), 32'(filtered_blue));
          check_field("run_last", 32'(e.last), 32'(run_last));
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_idle(out_calm);
      end
    end
  end

  task automatic apb_write(input logic idx, input logic [rgblap_pkg::APB_DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rgblap_pkg::REG_IMAGE_WIDTH) cfg_width = val[rgblap_pkg::IMG_W_W-1:0];
    else cfg_height = val[rgblap_pkg::IMG_H_W-1:0];
  endtask

  task automatic set_size(input int w, input int h);
    apb_write(rgblap_pkg::REG_IMAGE_WIDTH, rgblap_pkg::APB_DATA_W'(w));
    apb_write(rgblap_pkg::REG_IMAGE_HEIGHT, rgblap_pkg::APB_DATA_W'(h));
  endtask

  function automatic logic [rgblap_pkg::PIX_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return rgblap_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      pixel_q.push_back({rand_sample(), rand_sample(), rand_sample()});
    end
  endtask

  // a zero-result pixel may still be in the pipe when the last word has gone
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || filtered_q.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int rand_items;
    int w, h, n, r;
    for (int i = 0; i < MAX_W; i++) begin
      older_mem[i] = '0;
      prev_mem[i]  = '0;
    end
    for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) win[i][j] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sizes below the minimum, full and empty samples to hit both clamps
    set_size(0, 0);
    pixel_q.push_back(24'h000000);
    pixel_q.push_back(24'hffffff);
    pixel_q.push_back(24'hffffff);
    pixel_q.push_back(24'h000000);
    wait_idle();

    set_size(1, 3);
    pixel_q.push_back(24'h0000ff);
    pixel_q.push_back(24'h00ff00);
    pixel_q.push_back(24'hff0000);
    pixel_q.push_back(24'h808080);
    pixel_q.push_back(24'h030201);
    pixel_q.push_back(24'hfcfdfe);
    wait_idle();

    set_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      pixel_q.push_back({(i % 2) ? 8'hff : 8'h01, 8'(255 - i * 29), 8'(i * 37)});
    end
    wait_idle();

    // fills every line store entry that the random frames reach
    set_size(FILL_W, 2);
    queue_random(2 * FILL_W);
    wait_idle();

    // tallest frame; can leave counters past the frame for the next size
    set_size(2, 65535);
    queue_random(8);
    wait_idle();

    rand_items = 0;
    while (rand_items < 250) begin
      r = $urandom_range(0, 99);
      if (r < 80) w = $urandom_range(2, 10);
      else w = $urandom_range(11, FILL_W);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      n = (w < 2 ? 2 : w) * (h < 2 ? 2 : h);
      if ($urandom_range(0, 99) < 30) n = $urandom_range(1, 2 * n);
      if (n > 80) n = 80;
      set_size(w, h);
      queue_random(n);
      rand_items += n;
      wait_idle();
    end

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
